@@ sv/saoc_pkg.sv @@
// shared types and constants for the sorted array occurrence counter
`default_nettype none

package saoc_pkg;

  localparam int VAL_W = 32;
  localparam int CMD_W = 2;
  localparam int OCC_W = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  // controller to datapath
  typedef struct packed {
    logic load_start;
    logic load_append;
    logic query_start;
    logic issue;
    logic eval;
    logic capture;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
  } sts_t;

endpackage

`default_nettype wire

@@ sv/saoc_ram.sv @@
// generic ram, one write port and two registered read ports
`default_nettype none

module saoc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

@@ sv/saoc_dp.sv @@
// datapath: element store, length, two binary search lanes, result register
`default_nettype none

module saoc_dp
  import saoc_pkg::*;
#(
  parameter int STORE_DEPTH = 1024
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire ctl_t                    ctl_i,
  input  wire logic signed [VAL_W-1:0] value_i,
  output sts_t                         sts_o,
  output logic [OCC_W-1:0]             occurrences_o
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int LW = $clog2(STORE_DEPTH + 1);

  logic [LW-1:0]           len_q;
  logic signed [VAL_W-1:0] key_q;
  // lane a hunts the lowest match, lane b the highest; hi kept as hi plus one
  logic [LW-1:0]           lo_a_q, hip1_a_q, lo_b_q, hip1_b_q;
  logic [AW-1:0]           mid_a_q, mid_b_q, pos_a_q, pos_b_q;
  logic                    hit_a_q, hit_b_q;
  logic [OCC_W-1:0]        occ_q;

  logic                    act_a, act_b;
  logic [LW:0]             sum_a, sum_b;
  logic [AW-1:0]           mid_a, mid_b;
  logic signed [VAL_W-1:0] rd_a, rd_b;
  logic                    we;
  logic [AW-1:0]           waddr;
  logic [AW-1:0]           last;
  logic [LW-1:0]           cnt;

  assign act_a = lo_a_q < hip1_a_q;
  assign act_b = lo_b_q < hip1_b_q;
  assign sts_o.busy = act_a | act_b;

  assign sum_a = {1'b0, lo_a_q} + {1'b0, hip1_a_q} - (LW+1)'(1);
  assign sum_b = {1'b0, lo_b_q} + {1'b0, hip1_b_q} - (LW+1)'(1);
  assign mid_a = sum_a[AW:1];
  assign mid_b = sum_b[AW:1];

  assign we    = ctl_i.load_start | (ctl_i.load_append & (len_q < LW'(STORE_DEPTH)));
  assign waddr = ctl_i.load_start ? '0 : len_q[AW-1:0];

  saoc_ram #(
    .WIDTH(VAL_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (value_i),
    .raddr_a_i(mid_a),
    .rdata_a_o(rd_a),
    .raddr_b_i(mid_b),
    .rdata_b_o(rd_b)
  );

  // last match defaults to index zero when lane b saw no hit
  assign last = hit_b_q ? pos_b_q : '0;

  always_comb begin
    cnt = '0;
    if (hit_a_q && (last >= pos_a_q)) begin
      cnt = LW'(last) - LW'(pos_a_q) + LW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      lo_a_q   <= '0;
      hip1_a_q <= '0;
      lo_b_q   <= '0;
      hip1_b_q <= '0;
      hit_a_q  <= 1'b0;
      hit_b_q  <= 1'b0;
    end else begin
      if (ctl_i.load_start) begin
        len_q <= LW'(1);
      end else if (we) begin
        len_q <= len_q + LW'(1);
      end
      if (ctl_i.query_start) begin
        lo_a_q   <= '0;
        hip1_a_q <= len_q;
        lo_b_q   <= '0;
        hip1_b_q <= len_q;
        hit_a_q  <= 1'b0;
        hit_b_q  <= 1'b0;
      end else if (ctl_i.eval) begin
        if (act_a) begin
          if (rd_a == key_q) begin
            hit_a_q  <= 1'b1;
            hip1_a_q <= LW'(mid_a_q);
          end else if (rd_a < key_q) begin
            lo_a_q <= LW'(mid_a_q) + LW'(1);
          end else begin
            hip1_a_q <= LW'(mid_a_q);
          end
        end
        if (act_b) begin
          if (rd_b == key_q) begin
            hit_b_q <= 1'b1;
            lo_b_q  <= LW'(mid_b_q) + LW'(1);
          end else if (rd_b < key_q) begin
            lo_b_q <= LW'(mid_b_q) + LW'(1);
          end else begin
            hip1_b_q <= LW'(mid_b_q);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.query_start) begin
      key_q <= value_i;
    end
    if (ctl_i.issue) begin
      mid_a_q <= mid_a;
      mid_b_q <= mid_b;
    end
    if (ctl_i.eval && act_a && (rd_a == key_q)) begin
      pos_a_q <= mid_a_q;
    end
    if (ctl_i.eval && act_b && (rd_b == key_q)) begin
      pos_b_q <= mid_b_q;
    end
    if (ctl_i.capture) begin
      occ_q <= OCC_W'(cnt);
    end
  end

  assign occurrences_o = occ_q;

endmodule

`default_nettype wire

@@ sv/saoc_ctrl.sv @@
// controller: command decode, search sequencing, output valid
`default_nettype none

module saoc_ctrl
  import saoc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [CMD_W-1:0] command_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire sts_t             sts_i,
  output ctl_t                  ctl_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_EVAL,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    ctl_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_e'(command_i))
            CMD_START:  ctl_o.load_start  = 1'b1;
            CMD_APPEND: ctl_o.load_append = 1'b1;
            CMD_QUERY: begin
              ctl_o.query_start = 1'b1;
              state_d           = ST_ISSUE;
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        if (sts_i.busy) begin
          ctl_o.issue = 1'b1;
          state_d     = ST_EVAL;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_EVAL: begin
        ctl_o.eval = 1'b1;
        state_d    = ST_ISSUE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          ctl_o.capture = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctl_o.capture) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/sorted_array_occurrence_count_unit.sv @@
// top level of the sorted array occurrence counter
// usage:
// - input channel (in_valid_i/in_ready_o) carries command_i and value_i per item
// - start loads value_i at index 0 and sets the length to one; append writes
//   value_i at the next free index, dropped once STORE_DEPTH entries are held
// - elements must arrive in ascending signed order, otherwise counts are
//   meaningless
// - loads return nothing and leave ready high
// - a query runs two binary searches side by side, one for the lowest and one
//   for the highest matching index, sharing a store with two read ports
// - each search step issues the address, then does the registered read and
//   compare; steps repeat until both lanes finish, then out_valid_o is raised
// - the result sits in an output register; loads are still taken while it
//   waits, but a finished query holds until the output slot frees up
// - reset empties the store length and drops any pending result; store
//   contents are not cleared and need no clearing pass
`default_nettype none

module sorted_array_occurrence_count_unit
  import saoc_pkg::*;
#(
  parameter int STORE_DEPTH = 1024
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [CMD_W-1:0]        command_i,
  input  wire logic signed [VAL_W-1:0] value_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [OCC_W-1:0]             occurrences_o
);

  ctl_t ctl;
  sts_t sts;

  // sequencing of loads and search steps
  saoc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // store, search lanes and count register
  saoc_dp #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .value_i      (value_i),
    .sts_o        (sts),
    .occurrences_o(occurrences_o)
  );

  // both search lanes are finished whenever a new item may enter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !sts.busy)
    else $error("search lane still active while idle");

  // an accepted query blocks the input channel on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (command_i == CMD_QUERY)) |=> !in_ready_o)
    else $error("input taken during query");

  // a new count never overwrites a result still waiting at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.capture |-> (!out_valid_o || out_ready_i))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ test/tb_sorted_array_occurrence_count_unit.sv @@
// testbench for the sorted array occurrence counter: random sorted loads and counted queries
module tb_sorted_array_occurrence_count_unit
  import saoc_pkg::*;
();

  localparam int DEPTH = 1024;
  localparam int IDLE_PCT = 24;
  localparam int TOTAL_ITEMS = 1150;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT = 400000;
  // no dedicated member in the package for the leftover code
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // holds a copy of the element store and the counts still owed by the block
  class count_scoreboard #(int DEPTH = 1024);
    logic signed [VAL_W-1:0] elements [DEPTH];
    int unsigned stored_len;
    logic [OCC_W-1:0] expected_counts [$];
    int n_fail;

    function new();
      stored_len = 0;
      n_fail = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      n_fail++;
    endtask

    // binary search for the lowest or highest index holding key
    function bit locate(input logic signed [VAL_W-1:0] key, input bit want_last,
                        output int pos);
      int lo, hi, mid;
      bit hit;
      lo = 0;
      hi = int'(stored_len) - 1;
      hit = 1'b0;
      pos = 0;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (elements[mid] == key) begin
          hit = 1'b1;
          pos = mid;
          if (want_last) lo = mid + 1;
          else hi = mid - 1;
        end else if (elements[mid] < key) begin
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
      return hit;
    endfunction

    function logic [OCC_W-1:0] count_of(input logic signed [VAL_W-1:0] key);
      int first, last;
      logic [OCC_W-1:0] n;
      n = '0;
      if (locate(key, 1'b0, first)) begin
        void'(locate(key, 1'b1, last));
        // an unsorted store can put the last hit below the first
        if (last >= first) n = OCC_W'(last - first + 1);
      end
      return n;
    endfunction

    function void note_item(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] v);
      case (cmd)
        CMD_START: begin
          elements[0] = v;
          stored_len = 1;
        end
        CMD_APPEND: begin
          // a full store drops the element
          if (stored_len < DEPTH) begin
            elements[stored_len] = v;
            stored_len++;
          end
        end
        CMD_QUERY: expected_counts.push_back(count_of(v));
        default: ;
      endcase
    endfunction

    task check_count(input logic [OCC_W-1:0] got);
      logic [OCC_W-1:0] want;
      if (expected_counts.size() == 0) begin
        report($sformatf("count %0d with no query pending", got));
      end else begin
        want = expected_counts.pop_front();
        if (got !== want) report($sformatf("count %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [CMD_W-1:0] command_i;
  logic signed [VAL_W-1:0] value_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [OCC_W-1:0] occurrences_o;

  count_scoreboard #(DEPTH) sb;
  int items_sent;
  int cycles;
  bit no_gaps;
  logic signed [VAL_W-1:0] run_vals [$];

  sorted_array_occurrence_count_unit #(
    .STORE_DEPTH(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .occurrences_o(occurrences_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // hard stop in case the block hangs or a count never shows up
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random back-pressure except in the gap-free stretch
  always @(negedge clk_i) begin
    out_ready_i <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
  end

  // outputs are sampled at the rising edge, before the block updates them
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_count(occurrences_o);
  end

  // drive one item from a falling edge and hold it until the block takes it
  task send_item(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] val);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(cmd, val);
    items_sent++;
    @(negedge clk_i);
  endtask

  // query key picked mostly from the loaded run, sometimes next to it or anywhere
  task send_query(input int upto);
    int r;
    logic signed [VAL_W-1:0] key;
    r = $urandom_range(99);
    key = run_vals[$urandom_range(upto)];
    if (r >= 50 && r < 60) key = key + 32'sd1;
    else if (r >= 60 && r < 70) key = key - 32'sd1;
    else if (r >= 70 && r < 85) key = $signed($urandom);
    else if (r >= 85) begin
      case ($urandom_range(3))
        0: key = VAL_MIN;
        1: key = VAL_MAX;
        2: key = '0;
        default: key = -32'sd1;
      endcase
    end
    send_item(CMD_QUERY, key);
  endtask

  // ascending run with plenty of repeats, optionally with two entries swapped
  task send_run(input int n, input bit break_order);
    longint cur;
    int r, a, b;
    logic signed [VAL_W-1:0] tmp;
    run_vals.delete();
    case ($urandom_range(3))
      0: cur = longint'(VAL_MIN);
      1: cur = longint'($signed($urandom));
      2: cur = longint'($urandom_range(100)) - 50;
      default: cur = longint'(VAL_MAX) - longint'($urandom_range(100));
    endcase
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        r = $urandom_range(99);
        if (r < 40) cur += 0;
        else if (r < 75) cur += $urandom_range(3, 1);
        else if (r < 90) cur += $urandom_range(1000, 1);
        else cur += longint'($urandom);
        if (cur > longint'(VAL_MAX)) cur = longint'(VAL_MAX);
      end
      run_vals.push_back(VAL_W'(cur));
    end
    if (break_order && n > 2) begin
      a = $urandom_range(n - 1);
      b = $urandom_range(n - 1);
      tmp = run_vals[a];
      run_vals[a] = run_vals[b];
      run_vals[b] = tmp;
    end
    send_item(CMD_START, run_vals[0]);
    for (int i = 1; i < n; i++) begin
      send_item(CMD_APPEND, run_vals[i]);
      // queries mixed in with loads, over what is loaded so far
      if ($urandom_range(99) < 8) send_query(i);
    end
    repeat ($urandom_range(6, 1)) send_query(n - 1);
  endtask

  initial begin
    int goal, r, n;
    logic signed [VAL_W-1:0] x;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    command_i = CMD_START;
    value_i = '0;
    out_ready_i = 1'b0;
    no_gaps = 1'b0;
    items_sent = 0;
    cycles = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty store, append into an empty store
    send_item(CMD_QUERY, '0);
    send_item(CMD_APPEND, -32'sd5);
    send_item(CMD_QUERY, -32'sd5);
    // runs at both ends of the value range
    send_item(CMD_START, VAL_MIN);
    send_item(CMD_APPEND, VAL_MIN);
    send_item(CMD_APPEND, -32'sd1);
    send_item(CMD_APPEND, '0);
    send_item(CMD_APPEND, '0);
    send_item(CMD_APPEND, '0);
    send_item(CMD_APPEND, VAL_MAX);
    send_item(CMD_APPEND, VAL_MAX);
    send_item(CMD_QUERY, VAL_MIN);
    send_item(CMD_QUERY, '0);
    send_item(CMD_QUERY, VAL_MAX);
    send_item(CMD_QUERY, -32'sd1);
    send_item(CMD_QUERY, 32'sd1);
    send_item(CMD_QUERY, 32'sh7fff_fffe);
    // unused code must leave the store alone
    send_item(CMD_UNUSED, 32'sh1234_5678);
    send_item(CMD_QUERY, '0);
    // unsorted store
    send_item(CMD_START, 32'sd5);
    send_item(CMD_APPEND, 32'sd1);
    send_item(CMD_QUERY, 32'sd1);

    // full store of one value, then appends that must be dropped
    x = $signed($urandom);
    if (x == VAL_MAX) x = '0;
    send_item(CMD_START, x);
    for (int i = 1; i < DEPTH; i++) begin
      // stretch with no idling on either side
      no_gaps = (i >= 300) && (i < 600);
      send_item(CMD_APPEND, x);
    end
    no_gaps = 1'b0;
    send_item(CMD_APPEND, x);
    send_item(CMD_APPEND, x + 32'sd1);
    send_item(CMD_APPEND, x + 32'sd1);
    send_item(CMD_QUERY, x);
    send_item(CMD_QUERY, x + 32'sd1);
    send_item(CMD_QUERY, x - 32'sd1);

    // random part: mostly sorted runs, some noise and some broken runs
    goal = TOTAL_ITEMS;
    while (items_sent < goal) begin
      r = $urandom_range(99);
      if (r < 80 || r >= 90) begin
        r = $urandom_range(99);
        if (r < 85) n = $urandom_range(24, 1);
        else if (r < 97) n = $urandom_range(120, 25);
        else n = $urandom_range(400, 121);
        if (n > goal - items_sent) n = goal - items_sent;
        send_run(n, $urandom_range(99) < 50 && r >= 90);
      end else begin
        repeat ($urandom_range(10, 1)) begin
          send_item(CMD_W'($urandom_range(3)), $signed($urandom));
        end
      end
    end
    no_gaps = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.expected_counts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
